/* sv/vms_pkg.sv */
// Shared widths and register indexes for the vehicle mode supervisor.
package vms_pkg;

  localparam int unsigned POS_W  = 24;         // position coordinate width
  localparam int unsigned MAG_W  = POS_W;      // magnitude of one coordinate difference
  localparam int unsigned SQ_W   = 2 * MAG_W;  // one squared difference
  localparam int unsigned DIST_W = SQ_W + 1;   // sum of two squares

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOPPED_SPD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SETTLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAN_SETTLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_HOLD  = 3'd4;

endpackage

/* sv/vms_dist_sq.sv */
// Squared distance stage: registered squares of the coordinate differences.
module vms_dist_sq import vms_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  goal_x,
  input  logic signed [POS_W-1:0]  goal_y,
  output logic        [DIST_W-1:0] dist_sq
);

  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic        [POS_W:0] dx_neg;
  logic        [POS_W:0] dy_neg;
  logic        [MAG_W-1:0] dx_mag;
  logic        [MAG_W-1:0] dy_mag;
  logic        [SQ_W-1:0]  dx_sq_r;
  logic        [SQ_W-1:0]  dy_sq_r;

  // The difference of two 24-bit values fits in 25 bits signed; its
  // magnitude always fits in 24 bits.
  assign dx     = {pos_x[POS_W-1], pos_x} - {goal_x[POS_W-1], goal_x};
  assign dy     = {pos_y[POS_W-1], pos_y} - {goal_y[POS_W-1], goal_y};
  assign dx_neg = ~dx + 1'b1;
  assign dy_neg = ~dy + 1'b1;
  assign dx_mag = dx[POS_W] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
  assign dy_mag = dy[POS_W] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_sq_r <= dx_mag * dx_mag;
      dy_sq_r <= dy_mag * dy_mag;
    end
  end

  assign dist_sq = {1'b0, dx_sq_r} + {1'b0, dy_sq_r};

endmodule

/* sv/vehicle_mode_supervisor_fsm.sv */
// Vehicle mode supervisor: three-stage update pipeline and eight-state mode machine.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_ready  | now_ms, flags, ready_mask, route, positions,
//           |           |                      | speed sample
//   out     | output    | out_valid / out_ready| mode
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One update beat is accepted every cycle while the pipeline moves; its result beat is
// presented after it passes the input register, the squaring stage, then the mode
// decision into the output register.
// The two 24x24 squarers set the stage split; the mode decision is a combinational
// subtract, compare and select, so the state feeds back at full rate.
// Reset is synchronous and active low; it restores the register defaults, clears
// the mode state and empties every pipeline stage.
// When out_ready is low the stages fill up and hold; in_ready drops only when all
// three stages hold a beat.
module vehicle_mode_supervisor_fsm import vms_pkg::*; #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // update channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 in_now_ms,
  input  logic                        in_finalizing,
  input  logic                        in_emergency,
  input  logic [6:0]                  in_ready_mask,
  input  logic [15:0]                 in_route_id,
  input  logic                        in_engage_on,
  input  logic                        in_auto_mode,
  input  logic signed [POS_W-1:0]     in_pos_x,
  input  logic signed [POS_W-1:0]     in_pos_y,
  input  logic signed [POS_W-1:0]     in_goal_x,
  input  logic signed [POS_W-1:0]     in_goal_y,
  input  logic signed [15:0]          in_speed_mmps,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_mode,
  // configuration port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata
);

  // The run counters saturate at WINDOW, so they need to hold WINDOW itself.
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] WIN_MAX = CNT_W'(WINDOW);

  typedef enum logic [2:0] {
    M_INIT        = 3'd0,
    M_WAIT_ROUTE  = 3'd1,
    M_PLANNING    = 3'd2,
    M_WAIT_ENGAGE = 3'd3,
    M_DRIVING     = 3'd4,
    M_ARRIVED     = 3'd5,
    M_EMERGENCY   = 3'd6,
    M_FINAL       = 3'd7
  } mode_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The squared arrival threshold is kept in its own
  // register. The user must change configuration only while the pipeline is
  // empty; the block does not enforce it. Then the lag never reaches a beat.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   arrive_dist_r;
  logic [CFG_W-1:0]   stopped_spd_r;
  logic [CFG_W-1:0]   init_settle_r;
  logic [CFG_W-1:0]   plan_settle_r;
  logic [CFG_W-1:0]   arrive_hold_r;
  logic [2*CFG_W-1:0] thresh_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrive_dist_r <= 16'd150;
      stopped_spd_r <= 16'd10;
      init_settle_r <= 16'd1000;
      plan_settle_r <= 16'd1000;
      arrive_hold_r <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARRIVE_DIST: arrive_dist_r <= cfg_wdata;
        REG_STOPPED_SPD: stopped_spd_r <= cfg_wdata;
        REG_INIT_SETTLE: init_settle_r <= cfg_wdata;
        REG_PLAN_SETTLE: plan_settle_r <= cfg_wdata;
        REG_ARRIVE_HOLD: arrive_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thresh_sq_r <= arrive_dist_r * arrive_dist_r;
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves forward when the stage after it is
  // empty or moving itself; the mode state changes only when stage 2 hands its
  // beat to the output register.
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s2_adv;
  logic s2_free;
  logic s1_adv;
  logic in_take;

  assign out_free = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage 1: the update beat as received.
  logic [31:0]             s1_now_r;
  logic                    s1_fin_r;
  logic                    s1_emg_r;
  logic [6:0]              s1_rdy_r;
  logic [15:0]             s1_route_r;
  logic                    s1_engaged_r;
  logic signed [POS_W-1:0] s1_pos_x_r;
  logic signed [POS_W-1:0] s1_pos_y_r;
  logic signed [POS_W-1:0] s1_goal_x_r;
  logic signed [POS_W-1:0] s1_goal_y_r;
  logic signed [15:0]      s1_speed_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r     <= in_now_ms;
      s1_fin_r     <= in_finalizing;
      s1_emg_r     <= in_emergency;
      s1_rdy_r     <= in_ready_mask;
      s1_route_r   <= in_route_id;
      s1_engaged_r <= in_engage_on && in_auto_mode;
      s1_pos_x_r   <= in_pos_x;
      s1_pos_y_r   <= in_pos_y;
      s1_goal_x_r  <= in_goal_x;
      s1_goal_y_r  <= in_goal_y;
      s1_speed_r   <= in_speed_mmps;
    end
  end

  // Speed magnitude; the most negative sample maps to 32768, which still fits.
  logic [15:0] speed_neg;
  logic [15:0] speed_mag;
  logic        s1_stopped;

  assign speed_neg  = ~s1_speed_r + 1'b1;
  assign speed_mag  = s1_speed_r[15] ? speed_neg : s1_speed_r;
  assign s1_stopped = speed_mag <= stopped_spd_r;

  // Stage 2: the fields the mode decision needs, plus the squares.
  logic [31:0] s2_now_r;
  logic        s2_fin_r;
  logic        s2_emg_r;
  logic [6:0]  s2_rdy_r;
  logic [15:0] s2_route_r;
  logic        s2_engaged_r;
  logic        s2_stopped_r;
  logic [DIST_W-1:0] s2_dist_sq;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_now_r     <= s1_now_r;
      s2_fin_r     <= s1_fin_r;
      s2_emg_r     <= s1_emg_r;
      s2_rdy_r     <= s1_rdy_r;
      s2_route_r   <= s1_route_r;
      s2_engaged_r <= s1_engaged_r;
      s2_stopped_r <= s1_stopped;
    end
  end

  vms_dist_sq u_dist_sq (
    .clk     (clk),
    .en      (s1_adv),
    .pos_x   (s1_pos_x_r),
    .pos_y   (s1_pos_y_r),
    .goal_x  (s1_goal_x_r),
    .goal_y  (s1_goal_y_r),
    .dist_sq (s2_dist_sq)
  );

  // ---------------------------------------------------------------------------
  // Mode machine. The speed sample of the beat enters the run counters before
  // the arrival test, so the test sees the updated counters.
  // ---------------------------------------------------------------------------
  mode_t            mode_r, mode_nxt;
  mode_t            saved_r, saved_nxt;
  logic             init_wait_r, init_wait_nxt;
  logic             plan_wait_r, plan_wait_nxt;
  logic [31:0]      init_stamp_r, init_stamp_nxt;
  logic [31:0]      plan_stamp_r, plan_stamp_nxt;
  logic [31:0]      arrive_stamp_r, arrive_stamp_nxt;
  logic [15:0]      route_r, route_nxt;
  logic [CNT_W-1:0] still_run_r, still_run_nxt;
  logic [CNT_W-1:0] seen_cnt_r, seen_cnt_nxt;

  logic [31:0] init_elapsed;
  logic [31:0] plan_elapsed;
  logic [31:0] hold_elapsed;
  logic        near_goal;
  logic        arrived;
  logic        route_new;
  logic        has_route;
  logic        init_ready;
  logic        plan_ready;

  assign init_elapsed = s2_now_r - init_stamp_r;
  assign plan_elapsed = s2_now_r - plan_stamp_r;
  assign hold_elapsed = s2_now_r - arrive_stamp_r;
  assign near_goal    = s2_dist_sq < {{(DIST_W - 2*CFG_W){1'b0}}, thresh_sq_r};
  assign route_new    = s2_route_r != route_r;
  assign has_route    = s2_route_r != 16'd0;
  assign init_ready   = &s2_rdy_r[4:0];
  assign plan_ready   = &s2_rdy_r[6:5];

  always_comb begin
    mode_nxt         = mode_r;
    saved_nxt        = saved_r;
    init_wait_nxt    = init_wait_r;
    plan_wait_nxt    = plan_wait_r;
    init_stamp_nxt   = init_stamp_r;
    plan_stamp_nxt   = plan_stamp_r;
    arrive_stamp_nxt = arrive_stamp_r;
    route_nxt        = route_r;

    if (!s2_stopped_r) begin
      still_run_nxt = '0;
    end else if (still_run_r < WIN_MAX) begin
      still_run_nxt = still_run_r + 1'b1;
    end else begin
      still_run_nxt = WIN_MAX;
    end
    seen_cnt_nxt = (seen_cnt_r < WIN_MAX) ? seen_cnt_r + 1'b1 : WIN_MAX;

    // Stopped over the window means no moving sample among the last WINDOW samples seen.
    arrived = near_goal && (still_run_nxt >= seen_cnt_nxt);

    if (s2_fin_r) begin
      mode_nxt = M_FINAL;
    end else if (mode_r != M_EMERGENCY && s2_emg_r) begin
      saved_nxt = mode_r;
      mode_nxt  = M_EMERGENCY;
    end else begin
      case (mode_r)
        M_INIT: begin
          if (init_ready) begin
            if (!init_wait_r) begin
              init_wait_nxt  = 1'b1;
              init_stamp_nxt = s2_now_r;
            end else if (init_elapsed > {16'd0, init_settle_r}) begin
              init_wait_nxt = 1'b0;
              mode_nxt      = M_WAIT_ROUTE;
            end
          end
        end
        M_WAIT_ROUTE: begin
          if (route_new) begin
            mode_nxt = M_PLANNING;
          end else if (has_route && s2_engaged_r && !arrived) begin
            mode_nxt = M_DRIVING;
          end
        end
        M_PLANNING: begin
          route_nxt = s2_route_r;
          if (plan_ready) begin
            if (!plan_wait_r) begin
              plan_wait_nxt  = 1'b1;
              plan_stamp_nxt = s2_now_r;
            end else if (plan_elapsed > {16'd0, plan_settle_r}) begin
              plan_wait_nxt = 1'b0;
              mode_nxt      = M_WAIT_ENGAGE;
            end
          end
        end
        M_WAIT_ENGAGE: begin
          if (route_new) begin
            mode_nxt = M_PLANNING;
          end else if (arrived) begin
            arrive_stamp_nxt = s2_now_r;
            mode_nxt         = M_ARRIVED;
          end
        end
        M_DRIVING: begin
          if (route_new) begin
            mode_nxt = M_PLANNING;
          end else if (!s2_engaged_r) begin
            mode_nxt = M_WAIT_ENGAGE;
          end else if (arrived) begin
            arrive_stamp_nxt = s2_now_r;
            mode_nxt         = M_ARRIVED;
          end
        end
        M_ARRIVED: begin
          if (hold_elapsed > {16'd0, arrive_hold_r}) begin
            mode_nxt = M_WAIT_ROUTE;
          end
        end
        M_EMERGENCY: begin
          // Return to whatever mode was active when the emergency began.
          if (!s2_emg_r) begin
            mode_nxt = saved_r;
          end
        end
        default: ;
      endcase
    end
  end

  // The mode register doubles as the result register: it changes only when a
  // result beat is loaded, together with out_valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= M_INIT;
      saved_r        <= M_INIT;
      init_wait_r    <= 1'b0;
      plan_wait_r    <= 1'b0;
      init_stamp_r   <= '0;
      plan_stamp_r   <= '0;
      arrive_stamp_r <= '0;
      route_r        <= '0;
      still_run_r    <= '0;
      seen_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
      if (s2_adv) begin
        mode_r         <= mode_nxt;
        saved_r        <= saved_nxt;
        init_wait_r    <= init_wait_nxt;
        plan_wait_r    <= plan_wait_nxt;
        init_stamp_r   <= init_stamp_nxt;
        plan_stamp_r   <= plan_stamp_nxt;
        arrive_stamp_r <= arrive_stamp_nxt;
        route_r        <= route_nxt;
        still_run_r    <= still_run_nxt;
        seen_cnt_r     <= seen_cnt_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_mode  = mode_r;

`ifndef NO_ASSERTIONS
  // A finalizing beat always lands in the finalizing mode.
  a_fin_wins: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && s2_fin_r |=> mode_r == M_FINAL)
    else $error("finalizing beat did not produce the finalizing mode");

  // Entering the emergency mode saves the mode that was active.
  a_emg_save: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv && !s2_fin_r && s2_emg_r && mode_r != M_EMERGENCY
    |=> mode_r == M_EMERGENCY && saved_r == $past(mode_r))
    else $error("emergency entry did not save the previous mode");

  // The stopped run never outgrows the sample count, and neither passes WINDOW.
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    still_run_r <= seen_cnt_r && seen_cnt_r <= WIN_MAX)
    else $error("speed window counters out of bounds");

  // With all three stages full and the output stalled, no beat is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("update accepted into a full pipeline");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the vehicle mode supervisor: random trips, noise and config sweeps.
`timescale 1ns / 100ps

module tb_top;
  import vms_pkg::*;

  // The block registers the update, squares the distances, then decides the mode.
  localparam int PIPE_DEPTH   = 3;
  localparam int SPEED_WINDOW = 32;
  // Cycles in a row with no beat on either channel before the run is declared hung.
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 84;

  typedef enum logic [2:0] {
    MODE_INIT, MODE_WAIT_ROUTE, MODE_PLANNING, MODE_WAIT_ENGAGE,
    MODE_DRIVING, MODE_ARRIVED, MODE_EMERGENCY, MODE_FINAL
  } mode_t;

  // One update beat, in port order.
  typedef struct packed {
    logic [31:0]             now_ms;
    logic                    finalizing;
    logic                    emergency;
    logic [6:0]              ready_mask;
    logic [15:0]             route_id;
    logic                    engage_on;
    logic                    auto_mode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [15:0]      speed_mmps;
  } update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  update_t       cur_item = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [2:0]    out_mode;
  logic          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Updates waiting for the driver, and the modes the block owes us, oldest first.
  update_t pending_updates[$];
  mode_t   owed_modes[$];
  int      errors = 0;

  // Shadow of the configuration registers, indexed by register number.
  logic [CFG_W-1:0] reg_val [0:4];

  // Predicted supervisor state. It starts at the reset values and is only
  // touched by accepted update beats.
  mode_t       pred_mode   = MODE_INIT;
  mode_t       held_mode   = MODE_INIT;
  bit          init_armed  = 1'b0;
  bit          plan_armed  = 1'b0;
  logic [31:0] init_t0     = '0;
  logic [31:0] plan_t0     = '0;
  logic [31:0] arrive_t0   = '0;
  logic [15:0] route_now   = '0;
  int          stop_run    = 0;
  int          sample_cnt  = 0;

  // Stimulus generator context: a running clock, the route of the current
  // trip and its goal.
  logic [31:0] clock_ms;
  logic [15:0] trip_route = '0;
  int          goal_x = 0;
  int          goal_y = 0;
  int          queued = 0;

  // Driver and receiver bookkeeping.
  bit          in_taken  = 1'b0;
  int          burst_left = 1;
  int          gap_left   = 0;
  logic [15:0] stall_pat  = 16'hFFFF;
  logic [5:0]  pat_age    = '0;
  int          quiet      = 0;

  vehicle_mode_supervisor_fsm #(.WINDOW(SPEED_WINDOW)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_now_ms     (cur_item.now_ms),
    .in_finalizing (cur_item.finalizing),
    .in_emergency  (cur_item.emergency),
    .in_ready_mask (cur_item.ready_mask),
    .in_route_id   (cur_item.route_id),
    .in_engage_on  (cur_item.engage_on),
    .in_auto_mode  (cur_item.auto_mode),
    .in_pos_x      (cur_item.pos_x),
    .in_pos_y      (cur_item.pos_y),
    .in_goal_x     (cur_item.goal_x),
    .in_goal_y     (cur_item.goal_y),
    .in_speed_mmps (cur_item.speed_mmps),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mode      (out_mode),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mode decision for one update. The speed sample enters the stillness
  // window before arrival is judged, and the window counts as stopped only
  // when every sample seen so far (up to the window length) was stopped.
  function automatic mode_t advance_supervisor(update_t u);
    int          spd;
    int          mag;
    longint      dx;
    longint      dy;
    longint      d2;
    longint      th2;
    logic [31:0] span;
    bit          arrived;
    bit          route_new;
    bit          has_route;
    bit          engaged;
    mode_t       nxt;
    spd = $signed(u.speed_mmps);
    mag = (spd < 0) ? -spd : spd;
    if (mag <= int'(reg_val[REG_STOPPED_SPD])) begin
      stop_run = (stop_run < SPEED_WINDOW) ? stop_run + 1 : SPEED_WINDOW;
    end else begin
      stop_run = 0;
    end
    sample_cnt = (sample_cnt < SPEED_WINDOW) ? sample_cnt + 1 : SPEED_WINDOW;

    dx  = longint'($signed(u.pos_x)) - longint'($signed(u.goal_x));
    dy  = longint'($signed(u.pos_y)) - longint'($signed(u.goal_y));
    d2  = dx * dx + dy * dy;
    th2 = longint'(reg_val[REG_ARRIVE_DIST]) * longint'(reg_val[REG_ARRIVE_DIST]);
    arrived   = (d2 < th2) && (stop_run >= sample_cnt);
    route_new = (u.route_id != route_now);
    has_route = (u.route_id != 16'd0);
    engaged   = u.engage_on && u.auto_mode;
    nxt = pred_mode;

    if (u.finalizing) begin
      nxt = MODE_FINAL;
    end else if (pred_mode != MODE_EMERGENCY && u.emergency) begin
      // Whatever mode we were in, finalizing included, comes back afterwards.
      held_mode = pred_mode;
      nxt = MODE_EMERGENCY;
    end else begin
      case (pred_mode)
        MODE_INIT: begin
          // The settle timer is armed once; a drop in readiness does not disarm it.
          if (u.ready_mask[4:0] == 5'h1F) begin
            span = u.now_ms - init_t0;
            if (!init_armed) begin
              init_armed = 1'b1;
              init_t0 = u.now_ms;
            end else if (span > reg_val[REG_INIT_SETTLE]) begin
              init_armed = 1'b0;
              nxt = MODE_WAIT_ROUTE;
            end
          end
        end
        MODE_WAIT_ROUTE: begin
          if (route_new) begin
            nxt = MODE_PLANNING;
          end else if (has_route && engaged && !arrived) begin
            nxt = MODE_DRIVING;
          end
        end
        MODE_PLANNING: begin
          route_now = u.route_id;
          if (u.ready_mask[6:5] == 2'b11) begin
            span = u.now_ms - plan_t0;
            if (!plan_armed) begin
              plan_armed = 1'b1;
              plan_t0 = u.now_ms;
            end else if (span > reg_val[REG_PLAN_SETTLE]) begin
              plan_armed = 1'b0;
              nxt = MODE_WAIT_ENGAGE;
            end
          end
        end
        MODE_WAIT_ENGAGE: begin
          if (route_new) begin
            nxt = MODE_PLANNING;
          end else if (arrived) begin
            arrive_t0 = u.now_ms;
            nxt = MODE_ARRIVED;
          end
        end
        MODE_DRIVING: begin
          if (route_new) begin
            nxt = MODE_PLANNING;
          end else if (!engaged) begin
            nxt = MODE_WAIT_ENGAGE;
          end else if (arrived) begin
            arrive_t0 = u.now_ms;
            nxt = MODE_ARRIVED;
          end
        end
        MODE_ARRIVED: begin
          span = u.now_ms - arrive_t0;
          if (span > reg_val[REG_ARRIVE_HOLD]) begin
            nxt = MODE_WAIT_ROUTE;
          end
        end
        MODE_EMERGENCY: begin
          if (!u.emergency) begin
            nxt = held_mode;
          end
        end
        default: begin
          // Finalizing is terminal unless an emergency interrupts it.
        end
      endcase
    end
    pred_mode = nxt;
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. They read the register shadow so that time steps,
  // distances and speeds straddle whatever thresholds are currently set.
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] stopped_speed();
    int lim;
    int v;
    lim = reg_val[REG_STOPPED_SPD];
    if (lim > 32768) lim = 32768;
    v = $urandom_range(lim);
    if ($urandom_range(1)) v = -v;
    return 16'(v);
  endfunction

  function automatic logic [15:0] moving_speed();
    int lo;
    int v;
    lo = int'(reg_val[REG_STOPPED_SPD]) + 1;
    if (lo > 32768) return stopped_speed();
    v = $urandom_range(32768, lo);
    if ($urandom_range(1)) v = -v;
    return 16'(v);
  endfunction

  function automatic int near_offset();
    int h;
    h = int'(reg_val[REG_ARRIVE_DIST]) / 2;
    return int'($urandom_range(2 * h)) - h;
  endfunction

  function automatic int far_offset();
    int v;
    v = int'(reg_val[REG_ARRIVE_DIST]) + 1 + int'($urandom_range(200000));
    return $urandom_range(1) ? v : -v;
  endfunction

  // A step that needs two or three updates to exceed the given delay.
  function automatic int settle_step(int span);
    return span / 2 + 1 + int'($urandom_range(span / 4 + 3));
  endfunction

  function automatic update_t at_offset(update_t u, int ox, int oy);
    u.pos_x = POS_W'(goal_x + ox);
    u.pos_y = POS_W'(goal_y + oy);
    return u;
  endfunction

  // A trip update: the clock moves on, the vehicle sits on the goal, stopped.
  function automatic update_t fresh_item(int step);
    update_t u;
    u = '0;
    clock_ms = clock_ms + 32'(step);
    u.now_ms     = clock_ms;
    u.ready_mask = 7'($urandom);
    u.route_id   = trip_route;
    u.goal_x     = POS_W'(goal_x);
    u.goal_y     = POS_W'(goal_y);
    u.speed_mmps = stopped_speed();
    return at_offset(u, 0, 0);
  endfunction

  // Anything goes, except finalizing unless asked for, since it never clears.
  function automatic update_t noise_item(bit allow_fin);
    update_t u;
    u = '0;
    if ($urandom_range(7) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(70000);
    end
    u.now_ms     = clock_ms;
    u.finalizing = allow_fin & 1'($urandom_range(1));
    u.emergency  = ($urandom_range(3) == 0);
    u.ready_mask = 7'($urandom);
    case ($urandom_range(2))
      0:       u.route_id = 16'd0;
      1:       u.route_id = trip_route;
      default: u.route_id = 16'($urandom);
    endcase
    u.engage_on  = 1'($urandom_range(1));
    u.auto_mode  = 1'($urandom_range(1));
    u.pos_x      = POS_W'($urandom);
    u.pos_y      = POS_W'($urandom);
    u.goal_x     = POS_W'($urandom);
    u.goal_y     = POS_W'($urandom);
    u.speed_mmps = 16'($urandom);
    return u;
  endfunction

  // Append one update to the driver queue as it is.
  task automatic append_update(update_t u);
    pending_updates.insert(pending_updates.size(), u);
  endtask

  // Queue one update; now and then an emergency is reported on it.
  task automatic push_item(update_t u);
    if ($urandom_range(39) == 0) u.emergency = 1'b1;
    append_update(u);
    queued++;
  endtask

  // Sit near the goal with stopped samples, a few more or fewer than the
  // window, optionally ending right at the distance threshold.
  task automatic hold_still(bit engaged);
    update_t u;
    int      rim;
    repeat ($urandom_range(36, 26)) begin
      u = fresh_item($urandom_range(200));
      u.engage_on = engaged;
      u.auto_mode = engaged;
      push_item(at_offset(u, near_offset(), near_offset()));
    end
    if ($urandom_range(1)) begin
      rim = int'(reg_val[REG_ARRIVE_DIST]) - int'($urandom_range(1));
      u = fresh_item($urandom_range(200));
      u.engage_on = engaged;
      u.auto_mode = engaged;
      push_item(at_offset(u, rim, 0));
    end
  endtask

  // Let the arrived hold run out.
  task automatic linger();
    update_t u;
    repeat (3) begin
      u = fresh_item(settle_step(reg_val[REG_ARRIVE_HOLD]));
      push_item(at_offset(u, near_offset(), near_offset()));
    end
  endtask

  // A full mission: settle after init, take a new route, settle the planner,
  // arrive once while waiting for engage, drive off and arrive again. A rough
  // trip drops readiness during the settles and disturbs the drive.
  task automatic run_trip();
    update_t     u;
    bit          rough;
    logic [15:0] prior;
    rough = ($urandom_range(3) == 0);
    repeat (4) begin
      u = fresh_item(settle_step(reg_val[REG_INIT_SETTLE]));
      if (!rough || $urandom_range(3) != 0) u.ready_mask[4:0] = 5'h1F;
      push_item(u);
    end
    prior = trip_route;
    do begin
      trip_route = 16'($urandom);
    end while (trip_route == 16'd0 || trip_route == prior);
    goal_x = int'($urandom_range(8000000)) - 4000000;
    goal_y = int'($urandom_range(8000000)) - 4000000;
    repeat (5) begin
      u = fresh_item(settle_step(reg_val[REG_PLAN_SETTLE]));
      if (!rough || $urandom_range(3) != 0) u.ready_mask[6:5] = 2'b11;
      push_item(u);
    end
    repeat ($urandom_range(3, 1)) begin
      u = fresh_item($urandom_range(300));
      u.speed_mmps = moving_speed();
      push_item(at_offset(u, far_offset(), far_offset()));
    end
    hold_still(1'b0);
    linger();
    repeat ($urandom_range(5, 2)) begin
      u = fresh_item($urandom_range(300));
      u.engage_on  = 1'b1;
      u.auto_mode  = 1'b1;
      u.speed_mmps = moving_speed();
      push_item(at_offset(u, far_offset(), far_offset()));
    end
    if (rough) begin
      // Either a fresh route shows up mid-drive or the driver disengages.
      u = fresh_item($urandom_range(300));
      u.speed_mmps = moving_speed();
      if ($urandom_range(1)) begin
        u.route_id  = 16'($urandom);
        u.engage_on = 1'b1;
        u.auto_mode = 1'b1;
      end
      push_item(at_offset(u, far_offset(), far_offset()));
    end
    hold_still(1'b1);
    linger();
  endtask

  task automatic run_phase(int target);
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(8, 3)) push_item(noise_item(1'b0));
      end else begin
        run_trip();
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    // Indexes past the last register are dropped by the block.
    if (idx <= REG_ARRIVE_HOLD) reg_val[idx] = val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every update yields one mode beat, so nothing owed means the block is idle.
  task automatic wait_idle();
    while (pending_updates.size() != 0 || in_valid || owed_modes.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Update driver. Beats are sent in bursts of random length separated by
  // random gaps; about a third of the gaps are empty, which gives stretches of
  // back-to-back beats. The payload only changes once the beat was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_updates.size() != 0) begin
        cur_item <= pending_updates.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(20, 1);
          gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Every accepted update is run through the predictor right away; the
  // registers only change while no beat is in flight, so the shadow is valid.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      owed_modes.insert(owed_modes.size(), advance_supervisor(cur_item));
    end
  end

  // Result receiver: out_ready walks a rotating 16-bit pattern, replaced when
  // pat_age wraps. Some patterns are all ones, none is all zeros.
  always @(negedge clk) begin : recv_pattern
    logic [15:0] fresh;
    if (pat_age == '0) begin
      case ($urandom_range(3))
        0:       fresh = 16'hFFFF;
        1:       fresh = 16'($urandom) | 16'h0101;
        default: fresh = 16'($urandom);
      endcase
      if (fresh == '0) fresh = 16'h8001;
      stall_pat <= fresh;
      out_ready <= fresh[0];
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
      out_ready <= stall_pat[1];
    end
    pat_age <= pat_age + 1'b1;
  end

  // Result monitor: each mode beat must match the oldest owed mode.
  always @(posedge clk) begin : mode_check
    mode_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_modes.size() == 0) begin
        $display("%0t: mode beat %0d arrived with none owed", $time, out_mode);
        errors = errors + 1;
      end else begin
        want = owed_modes.pop_front();
        if (out_mode !== want) begin
          $display("%0t: mode mismatch, expected %0d (%s), got %0d",
                   $time, want, want.name(), out_mode);
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog: a long run of cycles without an accepted update or an owed
  // mode beat means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready && owed_modes.size() != 0)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Register settings change only between phases, once the
  // block has returned every owed mode.
  // ---------------------------------------------------------------------------
  initial begin
    update_t u;
    reg_val[REG_ARRIVE_DIST] = 16'd150;
    reg_val[REG_STOPPED_SPD] = 16'd10;
    reg_val[REG_INIT_SETTLE] = 16'd1000;
    reg_val[REG_PLAN_SETTLE] = 16'd1000;
    reg_val[REG_ARRIVE_HOLD] = 16'd2000;
    clock_ms = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset settings. An all-zero update leaves the
    // block initializing.
    u = '0;
    append_update(u);
    // Init ready just before the clock wraps, coordinates and speed at their
    // extremes in opposite directions.
    u.now_ms     = 32'hFFFF_FF00;
    u.ready_mask = 7'h1F;
    u.pos_x      = POS_W'(-8388608);
    u.goal_x     = POS_W'(8388607);
    u.pos_y      = POS_W'(8388607);
    u.goal_y     = POS_W'(-8388608);
    u.speed_mmps = 16'sh8000;
    append_update(u);
    // The settle delay is measured across the wrap: 1024 ms have passed.
    u.now_ms     = 32'h0000_0300;
    u.ready_mask = 7'h7F;
    u.speed_mmps = 16'sh7FFF;
    append_update(u);
    // Engaged but without any route: nothing happens.
    u.now_ms    = 32'h0000_0400;
    u.engage_on = 1'b1;
    u.auto_mode = 1'b1;
    append_update(u);
    u.now_ms   = 32'h0000_0500;
    u.route_id = 16'hFFFF;
    append_update(u);
    // Planner ready arms the timer, readiness drops, the timer stays armed.
    u.now_ms     = 32'h0000_0600;
    u.ready_mask = 7'h60;
    append_update(u);
    u.now_ms     = 32'h0000_1000;
    u.ready_mask = 7'h20;
    append_update(u);
    u.ready_mask = 7'h60;
    append_update(u);
    // Emergency raised twice, then cleared: back to waiting for engage.
    u.now_ms    = 32'h0000_1100;
    u.emergency = 1'b1;
    append_update(u);
    append_update(u);
    u.emergency = 1'b0;
    append_update(u);
    // A new route while waiting for engage sends us back to planning.
    u.route_id = 16'h1234;
    append_update(u);
    clock_ms   = 32'h0000_1200;
    trip_route = 16'h1234;

    run_phase(PHASE_ITEMS);

    // Everything at zero; the unused indexes must not disturb anything.
    wait_idle();
    for (int k = 0; k <= int'(REG_ARRIVE_HOLD); k++) write_reg(CFG_IDX_W'(k), '0);
    for (int k = int'(REG_ARRIVE_HOLD) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), 16'($urandom));
    end
    end_writes();
    run_phase(PHASE_ITEMS);

    // Everything at full scale: every sample counts as stopped.
    wait_idle();
    for (int k = 0; k <= int'(REG_ARRIVE_HOLD); k++) write_reg(CFG_IDX_W'(k), 16'hFFFF);
    end_writes();
    run_phase(PHASE_ITEMS);

    // Two settings in the range the vehicle would normally use.
    repeat (2) begin
      wait_idle();
      write_reg(REG_ARRIVE_DIST, 16'($urandom_range(2000, 20)));
      write_reg(REG_STOPPED_SPD, 16'($urandom_range(300)));
      write_reg(REG_INIT_SETTLE, 16'($urandom_range(3000)));
      write_reg(REG_PLAN_SETTLE, 16'($urandom_range(3000)));
      write_reg(REG_ARRIVE_HOLD, 16'($urandom_range(5000)));
      end_writes();
      run_phase(PHASE_ITEMS);
    end

    // Shutdown comes last since finalizing never clears. An emergency after
    // finalizing drops must return to finalizing once it is over.
    u = fresh_item(10);
    u.finalizing = 1'b1;
    append_update(u);
    u.emergency = 1'b1;
    append_update(u);
    u.finalizing = 1'b0;
    append_update(u);
    append_update(u);
    u.emergency = 1'b0;
    append_update(u);
    repeat (10) append_update(noise_item(1'b1));

    wait_idle();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
